// File: rtl/vehicle_can_signal_decoder_assert.svh
// ----------------------------------------------------------------------------
// vehicle can signal decoder assertion macros
// property wrappers for the top rtl file, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef VEHICLE_CAN_SIGNAL_DECODER_ASSERT_SVH
`define VEHICLE_CAN_SIGNAL_DECODER_ASSERT_SVH

`ifndef SYNTH

`define VCSD_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("vcsd: same-cycle check failed");

`define VCSD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("vcsd: next-cycle check failed");

`else

`define VCSD_ASSERT_IMP(name, clk, rst, pre, post)

`define VCSD_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

// File: rtl/vcsd_pkg.sv
// ----------------------------------------------------------------------------
// vcsd_pkg
// types and constants of the vehicle can signal decoder
// ----------------------------------------------------------------------------
`default_nettype none

package vcsd_pkg;

   localparam int unsigned IdWidth    = 11;
   localparam int unsigned LenWidth   = 4;
   localparam int unsigned CsrIdxW    = 3;
   localparam int unsigned CsrDataW   = 16;

   localparam logic [IdWidth-1:0]  TANK_ID_RESET    = 11'd800;
   localparam logic [15:0]         SPEED_GATE_RESET = 16'd832;

   localparam logic [7:0]          RAW_INVALID  = 8'hFF;
   localparam logic signed [15:0]  TEMP_INVALID = 16'sh8000;
   localparam logic [15:0]         TEMP_GAIN    = 16'd75;
   localparam logic [15:0]         TEMP_OFFSET  = 16'd4800;
   localparam logic [7:0]          TANK_MASK    = 8'h7F;

   localparam logic [LenWidth-1:0] LEN_ENGINE  = 4'd8;
   localparam logic [LenWidth-1:0] LEN_SPEED   = 4'd4;
   localparam logic [LenWidth-1:0] LEN_COOLANT = 4'd2;
   localparam logic [LenWidth-1:0] LEN_OIL     = 4'd4;
   localparam logic [LenWidth-1:0] LEN_TANK    = 4'd3;
   localparam logic [LenWidth-1:0] LEN_FUEL    = 4'd4;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENGINE_ID    = 3'd0,
      CSR_SPEED_ID     = 3'd1,
      CSR_COOLANT_ID   = 3'd2,
      CSR_OIL_ID       = 3'd3,
      CSR_TANK_ID      = 3'd4,
      CSR_FUEL_ID      = 3'd5,
      CSR_TORQUE_SCALE = 3'd6,
      CSR_SPEED_GATE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [IdWidth-1:0] engine_id;
      logic [IdWidth-1:0] speed_id;
      logic [IdWidth-1:0] coolant_id;
      logic [IdWidth-1:0] oil_id;
      logic [IdWidth-1:0] tank_id;
      logic [IdWidth-1:0] fuel_id;
      logic [15:0]        torque_scale;
      logic [15:0]        speed_gate;
   } cfg_type;

   typedef struct packed {
      logic [IdWidth-1:0]  frame_id;
      logic [LenWidth-1:0] frame_len;
      logic [7:0]          byte1;
      logic [7:0]          byte2;
      logic [7:0]          byte3;
      logic [7:0]          byte5;
      logic [7:0]          byte7;
   } frame_type;

   typedef struct packed {
      logic [13:0]        rpm;
      logic [7:0]         throttle;
      logic [15:0]        torque;
      logic [18:0]        vehicle_speed;
      logic               speed_ok;
      logic signed [15:0] coolant_temp;
      logic signed [15:0] oil_temp;
      logic [6:0]         tank_level;
      logic               tank_ok;
      logic [14:0]        fuel_count;
      logic               fuel_ok;
   } sig_type;

   typedef struct packed {
      logic    accepted;
      sig_type sig;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      engine_id:    '0,
      speed_id:     '0,
      coolant_id:   '0,
      oil_id:       '0,
      tank_id:      TANK_ID_RESET,
      fuel_id:      '0,
      torque_scale: '0,
      speed_gate:   SPEED_GATE_RESET
   };

   localparam sig_type SIG_RESET = '{
      rpm:           '0,
      throttle:      '0,
      torque:        '0,
      vehicle_speed: '0,
      speed_ok:      1'b0,
      coolant_temp:  TEMP_INVALID,
      oil_temp:      TEMP_INVALID,
      tank_level:    '0,
      tank_ok:       1'b0,
      fuel_count:    '0,
      fuel_ok:       1'b0
   };

   function automatic logic signed [15:0] temp_code(input logic [7:0] raw);
      logic [15:0] prod;
      begin
         prod = {8'd0, raw} * TEMP_GAIN;
         if (raw == RAW_INVALID) begin
            temp_code = TEMP_INVALID;
         end else begin
            temp_code = signed'(prod - TEMP_OFFSET);
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/vcsd_req_if.sv
// ----------------------------------------------------------------------------
// vcsd_req_if
// frame channel: valid/ready handshake with identifier, length and data bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface vcsd_req_if;
   import vcsd_pkg::*;

   logic                valid;
   logic                ready;
   logic [IdWidth-1:0]  frame_id;
   logic [LenWidth-1:0] frame_len;
   logic [7:0]          byte0;
   logic [7:0]          byte1;
   logic [7:0]          byte2;
   logic [7:0]          byte3;
   logic [7:0]          byte4;
   logic [7:0]          byte5;
   logic [7:0]          byte6;
   logic [7:0]          byte7;

   modport source (
      output valid, frame_id, frame_len,
      output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
      input  ready
   );

   modport sink (
      input  valid, frame_id, frame_len,
      input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/vcsd_rsp_if.sv
// ----------------------------------------------------------------------------
// vcsd_rsp_if
// result channel: valid/ready handshake with accepted flag and stored signals
// ----------------------------------------------------------------------------
`default_nettype none

interface vcsd_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [13:0]        rpm;
   logic [7:0]         throttle;
   logic [15:0]        torque;
   logic [18:0]        vehicle_speed;
   logic               speed_ok;
   logic signed [15:0] coolant_temp;
   logic signed [15:0] oil_temp;
   logic [6:0]         tank_level;
   logic               tank_ok;
   logic [14:0]        fuel_count;
   logic               fuel_ok;

   modport source (
      output valid, accepted, rpm, throttle, torque, vehicle_speed, speed_ok,
      output coolant_temp, oil_temp, tank_level, tank_ok, fuel_count, fuel_ok,
      input  ready
   );

   modport sink (
      input  valid, accepted, rpm, throttle, torque, vehicle_speed, speed_ok,
      input  coolant_temp, oil_temp, tank_level, tank_ok, fuel_count, fuel_ok,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/vcsd_decode.sv
// ----------------------------------------------------------------------------
// vcsd_decode
// identifier match, length check and signal update for one frame
// ----------------------------------------------------------------------------
`default_nettype none

module vcsd_decode (
   input  vcsd_pkg::frame_type frame,
   input  vcsd_pkg::cfg_type   cfg,
   input  vcsd_pkg::sig_type   cur,
   output vcsd_pkg::sig_type   nxt,
   output logic                accepted
);
   import vcsd_pkg::*;

   typedef enum logic [2:0] {
      KIND_ENGINE,
      KIND_SPEED,
      KIND_COOLANT,
      KIND_OIL,
      KIND_TANK,
      KIND_FUEL,
      KIND_NONE
   } kind_type;

   kind_type    kind;
   logic [15:0] word;
   logic [23:0] torque_prod;
   logic [18:0] speed_calc;
   logic [7:0]  gate_req;
   logic [7:0]  gate_forb;
   logic        gate_pass;

   assign word        = {frame.byte3, frame.byte2};
   assign torque_prod = {16'd0, frame.byte7} * {8'd0, cfg.torque_scale};
   assign speed_calc  = {1'b0, word, 2'b00} + {3'd0, word};
   assign gate_req    = cfg.speed_gate[7:0];
   assign gate_forb   = cfg.speed_gate[15:8];
   assign gate_pass   = ((frame.byte1 & gate_req) != 8'd0)
                     && ((frame.byte1 & gate_forb) == 8'd0);

   // first match in priority order
   always_comb begin
      if (frame.frame_id == cfg.engine_id) begin
         kind = KIND_ENGINE;
      end else if (frame.frame_id == cfg.speed_id) begin
         kind = KIND_SPEED;
      end else if (frame.frame_id == cfg.coolant_id) begin
         kind = KIND_COOLANT;
      end else if (frame.frame_id == cfg.oil_id) begin
         kind = KIND_OIL;
      end else if (frame.frame_id == cfg.tank_id) begin
         kind = KIND_TANK;
      end else if (frame.frame_id == cfg.fuel_id) begin
         kind = KIND_FUEL;
      end else begin
         kind = KIND_NONE;
      end
   end

   always_comb begin
      nxt      = cur;
      accepted = 1'b0;
      unique case (kind)
         KIND_ENGINE: begin
            if (frame.frame_len >= LEN_ENGINE) begin
               nxt.rpm      = word[15:2];
               nxt.throttle = frame.byte5;
               nxt.torque   = torque_prod[15:0];
               accepted     = 1'b1;
            end
         end
         KIND_SPEED: begin
            if (frame.frame_len >= LEN_SPEED) begin
               nxt.speed_ok = gate_pass;
               if (gate_pass) begin
                  nxt.vehicle_speed = speed_calc;
               end
               accepted = 1'b1;
            end
         end
         KIND_COOLANT: begin
            if (frame.frame_len >= LEN_COOLANT) begin
               nxt.coolant_temp = temp_code(frame.byte1);
               accepted         = 1'b1;
            end
         end
         KIND_OIL: begin
            if (frame.frame_len >= LEN_OIL) begin
               nxt.oil_temp = temp_code(frame.byte3);
               accepted     = 1'b1;
            end
         end
         KIND_TANK: begin
            if (frame.frame_len >= LEN_TANK) begin
               nxt.tank_level = 7'(frame.byte2 & TANK_MASK);
               nxt.tank_ok    = 1'b1;
               accepted       = 1'b1;
            end
         end
         KIND_FUEL: begin
            if (frame.frame_len >= LEN_FUEL) begin
               nxt.fuel_count = word[14:0];
               nxt.fuel_ok    = 1'b1;
               accepted       = 1'b1;
            end
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/vehicle_can_signal_decoder.sv
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder
// decodes received can frames into stored engine, speed, temperature and
// fuel signals; every frame beat returns one result beat
// ----------------------------------------------------------------------------
//  port       dir   handshake        payload
//  req_chan   in    valid / ready    frame_id, frame_len, byte0..byte7
//  rsp_chan   out   valid / ready    accepted and all stored signals
//  csr_*      in    csr_we only      csr_index, csr_wdata
//
//  two register stages: frame register, then decode into the result register
//  one frame beat per cycle sustained while the result side is not stalled;
//  a result beat is valid once its frame has passed both register stages
//  stored signals update as a frame leaves the frame register
//  reset sets stored signals, settings and valid flags to their defaults
//  a stalled result stage holds the frame register; req ready drops only then
// ----------------------------------------------------------------------------
`default_nettype none

`include "vehicle_can_signal_decoder_assert.svh"

module vehicle_can_signal_decoder (
   input  wire logic                    clock,
   input  wire logic                    reset,
   vcsd_req_if.sink                     req_chan,
   vcsd_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_we,
   input  wire logic [vcsd_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [vcsd_pkg::CsrDataW-1:0] csr_wdata
);
   import vcsd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   frame_type  frame_ff, frame_in;
   logic       stage_ff, stage_in;
   result_type res_ff, res_in;
   logic       out_ff, out_in;
   sig_type    state_ff, state_in;

   sig_type    dec_sig;
   logic       dec_acc;
   logic       req_take;
   logic       advance;

   vcsd_decode u_decode (
      .frame    (frame_ff),
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .nxt      (dec_sig),
      .accepted (dec_acc)
   );

   assign advance        = stage_ff && (!out_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENGINE_ID:    cfg_in.engine_id    = csr_wdata[IdWidth-1:0];
            CSR_SPEED_ID:     cfg_in.speed_id     = csr_wdata[IdWidth-1:0];
            CSR_COOLANT_ID:   cfg_in.coolant_id   = csr_wdata[IdWidth-1:0];
            CSR_OIL_ID:       cfg_in.oil_id       = csr_wdata[IdWidth-1:0];
            CSR_TANK_ID:      cfg_in.tank_id      = csr_wdata[IdWidth-1:0];
            CSR_FUEL_ID:      cfg_in.fuel_id      = csr_wdata[IdWidth-1:0];
            CSR_TORQUE_SCALE: cfg_in.torque_scale = csr_wdata;
            CSR_SPEED_GATE:   cfg_in.speed_gate   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      frame_in.frame_id  = req_chan.frame_id;
      frame_in.frame_len = req_chan.frame_len;
      frame_in.byte1     = req_chan.byte1;
      frame_in.byte2     = req_chan.byte2;
      frame_in.byte3     = req_chan.byte3;
      frame_in.byte5     = req_chan.byte5;
      frame_in.byte7     = req_chan.byte7;
   end

   always_comb begin
      stage_in = req_take || (stage_ff && !advance);
      out_in   = advance || (out_ff && !rsp_chan.ready);
      state_in = advance ? dec_sig : state_ff;
      res_in   = '{accepted: dec_acc, sig: dec_sig};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         stage_ff <= 1'b0;
         out_ff   <= 1'b0;
         state_ff <= SIG_RESET;
      end else begin
         cfg_ff   <= cfg_in;
         stage_ff <= stage_in;
         out_ff   <= out_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         frame_ff <= frame_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid         = out_ff;
   assign rsp_chan.accepted      = res_ff.accepted;
   assign rsp_chan.rpm           = res_ff.sig.rpm;
   assign rsp_chan.throttle      = res_ff.sig.throttle;
   assign rsp_chan.torque        = res_ff.sig.torque;
   assign rsp_chan.vehicle_speed = res_ff.sig.vehicle_speed;
   assign rsp_chan.speed_ok      = res_ff.sig.speed_ok;
   assign rsp_chan.coolant_temp  = res_ff.sig.coolant_temp;
   assign rsp_chan.oil_temp      = res_ff.sig.oil_temp;
   assign rsp_chan.tank_level    = res_ff.sig.tank_level;
   assign rsp_chan.tank_ok       = res_ff.sig.tank_ok;
   assign rsp_chan.fuel_count    = res_ff.sig.fuel_count;
   assign rsp_chan.fuel_ok       = res_ff.sig.fuel_ok;

   // a decoded frame always lands in the result register
   `VCSD_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_ff)
   // a pending result beat always mirrors the stored signals
   `VCSD_ASSERT_IMP(a_result_matches_state, clock, reset, out_ff, res_ff.sig == state_ff)
   // a rejected frame leaves the stored signals alone
   `VCSD_ASSERT_NEXT(a_reject_keeps_state, clock, reset, advance && !dec_acc,
                     state_ff == $past(state_ff))
   // tank and fuel flags only ever set
   `VCSD_ASSERT_NEXT(a_tank_ok_sticky, clock, reset, state_ff.tank_ok, state_ff.tank_ok)
   `VCSD_ASSERT_NEXT(a_fuel_ok_sticky, clock, reset, state_ff.fuel_ok, state_ff.fuel_ok)

endmodule

`default_nettype wire

// File: dv/can_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_decode_checker
// watches the frame and result channels and the register port, keeps its own
// copy of the settings and stored signals, predicts each result beat and
// compares it field by field, in order, with what the decoder returns
// ----------------------------------------------------------------------------
module can_decode_checker (
   input  logic                          clock,
   input  logic                          reset,
   vcsd_req_if                           req_chan,
   vcsd_rsp_if                           rsp_chan,
   input  logic                          csr_we,
   input  logic [vcsd_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [vcsd_pkg::CsrDataW-1:0] csr_wdata,
   output int                            mismatches,
   output int                            pending,
   output int                            decoded
);
   import vcsd_pkg::*;

   localparam int PrintCap = 100;

   cfg_type    setting;
   sig_type    stored;
   result_type expected_results[$];

   function automatic logic signed [15:0] centi_celsius(input logic [7:0] raw);
      int value;
      value = int'(raw) * 75 - 4800;
      if (raw == RAW_INVALID) begin
         return TEMP_INVALID;
      end
      return value[15:0];
   endfunction

   // updates the stored signals and returns the result beat for one frame
   function automatic result_type predict_beat(input frame_type f);
      logic [15:0] word;
      logic [23:0] product;
      logic        gate_open;
      result_type  r;
      word      = {f.byte3, f.byte2};
      product   = f.byte7 * setting.torque_scale;
      gate_open = (|(f.byte1 & setting.speed_gate[7:0]))
                  && !(|(f.byte1 & setting.speed_gate[15:8]));
      r.accepted = 1'b0;
      // first matching id wins, a short frame is rejected and changes nothing
      if (f.frame_id == setting.engine_id) begin
         if (f.frame_len >= LEN_ENGINE) begin
            stored.rpm      = word[15:2];
            stored.throttle = f.byte5;
            stored.torque   = product[15:0];
            r.accepted      = 1'b1;
         end
      end else if (f.frame_id == setting.speed_id) begin
         if (f.frame_len >= LEN_SPEED) begin
            stored.speed_ok = gate_open;
            if (gate_open) begin
               stored.vehicle_speed = {3'b000, word} * 19'd5;
            end
            r.accepted = 1'b1;
         end
      end else if (f.frame_id == setting.coolant_id) begin
         if (f.frame_len >= LEN_COOLANT) begin
            stored.coolant_temp = centi_celsius(f.byte1);
            r.accepted          = 1'b1;
         end
      end else if (f.frame_id == setting.oil_id) begin
         if (f.frame_len >= LEN_OIL) begin
            stored.oil_temp = centi_celsius(f.byte3);
            r.accepted      = 1'b1;
         end
      end else if (f.frame_id == setting.tank_id) begin
         if (f.frame_len >= LEN_TANK) begin
            stored.tank_level = f.byte2[6:0];
            stored.tank_ok    = 1'b1;
            r.accepted        = 1'b1;
         end
      end else if (f.frame_id == setting.fuel_id) begin
         if (f.frame_len >= LEN_FUEL) begin
            stored.fuel_count = word[14:0];
            stored.fuel_ok    = 1'b1;
            r.accepted        = 1'b1;
         end
      end
      r.sig = stored;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PrintCap) begin
         $display("[%0t] checker: %s", $time, what);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
      end
   endtask

   always @(posedge clock) begin
      frame_type  beat;
      result_type want;
      if (reset) begin
         setting = CFG_RESET;
         stored  = SIG_RESET;
         expected_results.delete();
         pending    = 0;
         mismatches = 0;
         decoded    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENGINE_ID:    setting.engine_id    = csr_wdata[IdWidth-1:0];
               CSR_SPEED_ID:     setting.speed_id     = csr_wdata[IdWidth-1:0];
               CSR_COOLANT_ID:   setting.coolant_id   = csr_wdata[IdWidth-1:0];
               CSR_OIL_ID:       setting.oil_id       = csr_wdata[IdWidth-1:0];
               CSR_TANK_ID:      setting.tank_id      = csr_wdata[IdWidth-1:0];
               CSR_FUEL_ID:      setting.fuel_id      = csr_wdata[IdWidth-1:0];
               CSR_TORQUE_SCALE: setting.torque_scale = csr_wdata;
               CSR_SPEED_GATE:   setting.speed_gate   = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            beat.frame_id  = req_chan.frame_id;
            beat.frame_len = req_chan.frame_len;
            beat.byte1     = req_chan.byte1;
            beat.byte2     = req_chan.byte2;
            beat.byte3     = req_chan.byte3;
            beat.byte5     = req_chan.byte5;
            beat.byte7     = req_chan.byte7;
            want = predict_beat(beat);
            if (want.accepted) begin
               decoded++;
            end
            expected_results.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with no frame outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("accepted", rsp_chan.accepted, want.accepted);
               check_field("rpm", rsp_chan.rpm, want.sig.rpm);
               check_field("throttle", rsp_chan.throttle, want.sig.throttle);
               check_field("torque", rsp_chan.torque, want.sig.torque);
               check_field("vehicle_speed", rsp_chan.vehicle_speed,
                           want.sig.vehicle_speed);
               check_field("speed_ok", rsp_chan.speed_ok, want.sig.speed_ok);
               check_field("coolant_temp", rsp_chan.coolant_temp, want.sig.coolant_temp);
               check_field("oil_temp", rsp_chan.oil_temp, want.sig.oil_temp);
               check_field("tank_level", rsp_chan.tank_level, want.sig.tank_level);
               check_field("tank_ok", rsp_chan.tank_ok, want.sig.tank_ok);
               check_field("fuel_count", rsp_chan.fuel_count, want.sig.fuel_count);
               check_field("fuel_ok", rsp_chan.fuel_ok, want.sig.fuel_ok);
            end
         end
         pending = expected_results.size();
      end
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives can frames into the signal decoder under a series of register
// settings: a directed pass over id priority, length limits, the speed gate
// and the temperature codes, then random phases of mostly matching frames,
// with random gaps on the frame side and random stalls on the result side
// ----------------------------------------------------------------------------
module testbench;
   import vcsd_pkg::*;

   localparam int RandomPhases   = 8;
   localparam int FramesPerPhase = 216;
   localparam int WatchdogLimit  = 2000;

   typedef struct packed {
      logic [IdWidth-1:0]  id;
      logic [LenWidth-1:0] len;
      logic [7:0][7:0]     data;
   } can_frame_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int      mismatches;
   int      pending;
   int      decoded;
   int      frames_sent = 0;
   int      settings_used = 0;
   int      stall_left = 0;
   int      quiet_cycles = 0;
   logic    steady = 1'b0;
   cfg_type current;

   vcsd_req_if req_chan ();
   vcsd_rsp_if rsp_chan ();

   vehicle_can_signal_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   can_decode_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .decoded    (decoded)
   );

   always #6 clock = ~clock;

   function automatic int draw_idle();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic can_frame_type make_frame(input logic [IdWidth-1:0] id,
                                                input logic [LenWidth-1:0] len,
                                                input logic [7:0] b1, input logic [7:0] b2,
                                                input logic [7:0] b3, input logic [7:0] b5,
                                                input logic [7:0] b7);
      can_frame_type f;
      f.id  = id;
      f.len = len;
      f.data = {b7, 8'($urandom), b5, 8'($urandom), b3, b2, b1, 8'($urandom)};
      return f;
   endfunction

   // mostly frames aimed at a configured id, the rest random ids
   function automatic can_frame_type pick_frame();
      can_frame_type f;
      int r;
      case ($urandom_range(0, 7))
         0:       f.id = current.engine_id;
         1:       f.id = current.speed_id;
         2:       f.id = current.coolant_id;
         3:       f.id = current.oil_id;
         4:       f.id = current.tank_id;
         5:       f.id = current.fuel_id;
         default: f.id = 11'($urandom);
      endcase
      r = $urandom_range(0, 9);
      if (r < 5) begin
         f.len = 4'd8;
      end else if (r < 7) begin
         f.len = 4'($urandom_range(9, 15));
      end else begin
         f.len = 4'($urandom_range(0, 7));
      end
      for (int i = 0; i < 8; i++) begin
         f.data[i] = rand_byte();
      end
      return f;
   endfunction

   function automatic cfg_type random_settings(input int phase);
      cfg_type c;
      c.engine_id    = 11'($urandom);
      c.speed_id     = 11'($urandom);
      c.coolant_id   = 11'($urandom);
      c.oil_id       = 11'($urandom);
      c.tank_id      = 11'($urandom);
      c.fuel_id      = 11'($urandom);
      c.torque_scale = 16'($urandom);
      c.speed_gate   = {8'($urandom) & 8'($urandom) & 8'($urandom), 8'($urandom)};
      if (phase == 0) begin
         c.engine_id    = '0;
         c.fuel_id      = '1;
         c.torque_scale = 16'hFFFF;
         c.speed_gate   = 16'h00FF;
      end else if (phase == 1) begin
         c.torque_scale = 16'h0000;
         c.speed_gate   = 16'hFF00;
      end else if ($urandom_range(0, 2) == 0) begin
         c.fuel_id = c.speed_id;
         c.oil_id  = c.coolant_id;
      end
      return c;
   endfunction

   // one beat on the frame channel; valid stays up when no gap follows
   task automatic send_frame(input can_frame_type f);
      int gap;
      gap = draw_idle();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.frame_id  <= f.id;
      req_chan.frame_len <= f.len;
      req_chan.byte0     <= f.data[0];
      req_chan.byte1     <= f.data[1];
      req_chan.byte2     <= f.data[2];
      req_chan.byte3     <= f.data[3];
      req_chan.byte4     <= f.data[4];
      req_chan.byte5     <= f.data[5];
      req_chan.byte6     <= f.data[6];
      req_chan.byte7     <= f.data[7];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      frames_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // called at a falling edge with the decoder idle; id registers get junk above
   task automatic apply_settings(input cfg_type c);
      write_reg(CSR_ENGINE_ID, {5'($urandom), c.engine_id});
      write_reg(CSR_SPEED_ID, {5'($urandom), c.speed_id});
      write_reg(CSR_COOLANT_ID, {5'($urandom), c.coolant_id});
      write_reg(CSR_OIL_ID, {5'($urandom), c.oil_id});
      write_reg(CSR_TANK_ID, {5'($urandom), c.tank_id});
      write_reg(CSR_FUEL_ID, {5'($urandom), c.fuel_id});
      write_reg(CSR_TORQUE_SCALE, c.torque_scale);
      write_reg(CSR_SPEED_GATE, c.speed_gate);
      csr_we <= 1'b0;
      current = c;
      settings_used++;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= draw_idle();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("watchdog: no beat for %0d cycles", WatchdogLimit);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_ENGINE_ID;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.frame_id  = '0;
      req_chan.frame_len = '0;
      req_chan.byte0     = '0;
      req_chan.byte1     = '0;
      req_chan.byte2     = '0;
      req_chan.byte3     = '0;
      req_chan.byte4     = '0;
      req_chan.byte5     = '0;
      req_chan.byte6     = '0;
      req_chan.byte7     = '0;
      rsp_chan.ready     = 1'b0;
      current            = CFG_RESET;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset ids: engine, speed, coolant, oil and fuel share id 0
      send_frame(make_frame(11'h000, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(make_frame(11'h000, 4'd7, 8'h40, 8'h11, 8'h22, 8'h33, 8'h44));
      send_frame(make_frame(11'd800, 4'd3, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'd800, 4'd2, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00));
      settle();

      apply_settings('{engine_id: 11'h7FF, speed_id: 11'h100, coolant_id: 11'h101,
                       oil_id: 11'h102, tank_id: 11'h000, fuel_id: 11'h7FE,
                       torque_scale: 16'hFFFF, speed_gate: 16'h8003});
      send_frame(make_frame(11'h7FF, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h7FF, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(make_frame(11'h100, 4'd4, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00));
      send_frame(make_frame(11'h100, 4'd4, 8'h81, 8'h12, 8'h34, 8'h00, 8'h00));
      send_frame(make_frame(11'h100, 4'd4, 8'h00, 8'h56, 8'h78, 8'h00, 8'h00));
      send_frame(make_frame(11'h100, 4'd3, 8'h01, 8'h9A, 8'hBC, 8'h00, 8'h00));
      send_frame(make_frame(11'h101, 4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h101, 4'd2, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h101, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h102, 4'd4, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h00));
      send_frame(make_frame(11'h102, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h000, 4'd3, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h7FE, 4'd4, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00));
      send_frame(make_frame(11'h7FE, 4'd15, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00));
      send_frame(make_frame(11'h555, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_frame(make_frame(11'h101, 4'd0, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00));
      settle();

      // every id the same: the engine entry alone decides
      apply_settings('{engine_id: 11'h2AA, speed_id: 11'h2AA, coolant_id: 11'h2AA,
                       oil_id: 11'h2AA, tank_id: 11'h2AA, fuel_id: 11'h2AA,
                       torque_scale: 16'h0001, speed_gate: 16'hFF00});
      send_frame(make_frame(11'h2AA, 4'd4, 8'hFF, 8'h12, 8'h34, 8'h00, 8'h00));
      send_frame(make_frame(11'h2AA, 4'd8, 8'hFF, 8'h34, 8'h12, 8'h99, 8'h7F));
      settle();

      apply_settings('{engine_id: 11'h001, speed_id: 11'h002, coolant_id: 11'h002,
                       oil_id: 11'h003, tank_id: 11'h004, fuel_id: 11'h005,
                       torque_scale: 16'h0100, speed_gate: 16'h00FF});
      send_frame(make_frame(11'h002, 4'd2, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00));
      send_frame(make_frame(11'h002, 4'd4, 8'hFF, 8'h21, 8'h43, 8'h00, 8'h00));
      settle();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         apply_settings(random_settings(phase));
         steady = (phase % 3 == 2);
         repeat (FramesPerPhase) send_frame(pick_frame());
         settle();
      end
      steady = 1'b0;

      repeat (8) @(negedge clock);
      $display("covered %0d frames under %0d register settings", frames_sent,
               settings_used);
      $display("%0d frames decoded, every result beat compared field by field", decoded);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
